// ----- rtl/core/hps_pkg.sv -----
package hps_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
   localparam int DIM_W       = 13;
   localparam int CMP_W       = ((COL_BITS + 1) > DIM_W) ?
                                ((ROW_BITS + 1) > (COL_BITS + 1) ? ROW_BITS + 1 : COL_BITS + 1) :
                                ((ROW_BITS + 1) > DIM_W ? ROW_BITS + 1 : DIM_W);
   localparam int AMT_W       = 10;
   localparam int AMT_MAX     = 768;
   localparam int BITS_W      = 5;
   localparam int SAMPLE_W    = 16;
   localparam int NUM_CH      = 3;
   localparam int HP_W        = 21;
   localparam int PROD_W      = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [DIM_W-1:0]  RESET_WIDTH  = 13'd640;
   localparam logic [DIM_W-1:0]  RESET_HEIGHT = 13'd480;
   localparam logic [AMT_W-1:0]  RESET_AMOUNT = 10'd256;
   localparam logic [BITS_W-1:0] RESET_BITS   = 5'd8;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_AMOUNT       = 2'd2,
      REG_SAMPLE_BITS  = 2'd3
   } csr_index_type;

   // channel 0 is red, 1 green, 2 blue
   typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] pixel_type;

   typedef struct packed {
      pixel_type above;
      pixel_type middle;
   } line_type;

   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type cur;
   } column_type;

   typedef struct packed {
      logic main;
      logic last_row;
      logic right;
      logic right_last;
      logic left_rep;
   } emit_type;

   typedef struct packed {
      column_type col;
      emit_type   emit;
   } job_type;

   typedef struct packed {
      logic [CMP_W-1:0]    width;
      logic [CMP_W-1:0]    height;
      logic [AMT_W-1:0]    amount;
      logic [SAMPLE_W-1:0] mask;
   } cfg_type;

endpackage

// ----- rtl/core/hps_req_if.sv -----
interface hps_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample_r;
   logic [15:0] sample_g;
   logic [15:0] sample_b;

   modport source (output valid, output sample_r, output sample_g, output sample_b,
                   input ready);
   modport sink (input valid, input sample_r, input sample_g, input sample_b,
                 output ready);
endinterface

// ----- rtl/core/hps_rsp_if.sv -----
interface hps_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_r;
   logic [15:0] out_g;
   logic [15:0] out_b;
   logic        frame_end;
   logic        last_of_run;

   modport source (output valid, output out_r, output out_g, output out_b,
                   output frame_end, output last_of_run, input ready);
   modport sink (input valid, input out_r, input out_g, input out_b,
                 input frame_end, input last_of_run, output ready);
endinterface

// ----- rtl/core/hps_ram.sv -----
module hps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/core/hps_front.sv -----
module hps_front (
   input  logic             clock,
   input  logic             reset,
   hps_req_if.sink          req,
   input  hps_pkg::cfg_type cfg,
   input  logic             restart,
   output logic             q_valid,
   input  logic             q_ready,
   output hps_pkg::job_type q_job
);
   import hps_pkg::*;

   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic                f1_valid_ff, f1_valid_in;
   logic [COL_BITS-1:0] f1_x_ff;
   logic                f1_y1_ff, f1_y2_ff;
   pixel_type           f1_cur_ff;
   emit_type            f1_emit_ff;

   logic                accept, push, wrapped;
   logic [COL_BITS-1:0] x_eff;
   logic [ROW_BITS-1:0] y_eff;
   logic [CMP_W-1:0]    x_next, y_next;
   pixel_type           cur, mid, top;
   line_type            line_rd, line_wr;
   logic [$bits(line_type)-1:0] ram_rdata;

   assign wrapped = (CMP_W'(col_ff) >= cfg.width) || (CMP_W'(row_ff) >= cfg.height);
   assign x_eff   = wrapped ? '0 : col_ff;
   assign y_eff   = wrapped ? '0 : row_ff;
   assign x_next  = CMP_W'(x_eff) + CMP_W'(1);
   assign y_next  = CMP_W'(y_eff) + CMP_W'(1);

   assign push      = f1_valid_ff && q_ready;
   assign req.ready = !f1_valid_ff || q_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      cur[0] = req.sample_r & cfg.mask;
      cur[1] = req.sample_g & cfg.mask;
      cur[2] = req.sample_b & cfg.mask;
   end

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      f1_valid_in = f1_valid_ff;
      if (push) begin
         f1_valid_in = 1'b0;
      end
      if (accept) begin
         f1_valid_in = 1'b1;
         if (x_next >= cfg.width) begin
            col_in = '0;
            row_in = (y_next >= cfg.height) ? '0 : y_next[ROW_BITS-1:0];
         end else begin
            col_in = x_next[COL_BITS-1:0];
            row_in = y_eff;
         end
      end
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         f1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_x_ff                 <= x_eff;
         f1_y1_ff                <= (y_eff != '0);
         f1_y2_ff                <= (CMP_W'(y_eff) >= CMP_W'(2));
         f1_cur_ff               <= cur;
         f1_emit_ff.main         <= (y_eff != '0) && (x_eff != '0);
         f1_emit_ff.last_row     <= (y_eff != '0) && (x_eff != '0) &&
                                    (y_next == cfg.height);
         f1_emit_ff.right        <= (y_eff != '0) && (x_eff != '0) &&
                                    (x_next == cfg.width);
         f1_emit_ff.right_last   <= (y_eff != '0) && (x_eff != '0) &&
                                    (x_next == cfg.width) && (y_next == cfg.height);
         f1_emit_ff.left_rep     <= (x_eff == COL_BITS'(1));
      end
   end

   assign line_rd = line_type'(ram_rdata);
   // replicate the top border rows
   assign mid = f1_y1_ff ? line_rd.middle : f1_cur_ff;
   assign top = f1_y2_ff ? line_rd.above : mid;

   assign line_wr.above  = mid;
   assign line_wr.middle = f1_cur_ff;

   hps_ram #(
      .WIDTH ($bits(line_type)),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (push),
      .waddr (f1_x_ff),
      .wdata (line_wr),
      .re    (accept),
      .raddr (x_eff),
      .rdata (ram_rdata)
   );

   assign q_valid     = f1_valid_ff;
   assign q_job.col.top = top;
   assign q_job.col.mid = mid;
   assign q_job.col.cur = f1_cur_ff;
   assign q_job.emit    = f1_emit_ff;
endmodule

// ----- rtl/core/hps_queue.sv -----
module hps_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  hps_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output hps_pkg::job_type out_job
);
   import hps_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             wr, rd;

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job   = entries_ff[rd_ptr_ff];
   assign wr        = in_valid && in_ready;
   assign rd        = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr ? PTR_W'(wr_ptr_ff + PTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = rd ? PTR_W'(rd_ptr_ff + PTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr && !rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd && !wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         entries_ff[wr_ptr_ff] <= in_job;
      end
   end
endmodule

// ----- rtl/core/hps_back.sv -----
module hps_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  hps_pkg::job_type q_job,
   input  hps_pkg::cfg_type cfg,
   hps_rsp_if.source        rsp
);
   import hps_pkg::*;

   pixel_type win_ff [3][3];   // [column][row]
   emit_type  pend_ff, pend_in;

   logic      any, issue, rem_empty, pop;
   logic      free1, free2, free3, out_move;
   emit_type  rem;
   logic [1:0] lc, cc, rc, ur, mr, dr;
   logic      sel_frame;

   logic      v1_ff, v2_ff, v3_ff, vo_ff;
   pixel_type s1_ctr_ff, s2_ctr_ff, s3_ctr_ff;
   pixel_type s1_nb_ff [8];
   logic      s1_fe_ff, s2_fe_ff, s3_fe_ff, o_fe_ff;
   logic      s1_lr_ff, s2_lr_ff, s3_lr_ff, o_lr_ff;
   logic signed [HP_W-1:0]   s2_hp_ff [NUM_CH];
   logic signed [PROD_W-1:0] s3_prod_ff [NUM_CH];
   logic [SAMPLE_W-1:0]      o_val_ff [NUM_CH];
   logic [SAMPLE_W-1:0]      o_val_in [NUM_CH];

   assign any = pend_ff.main || pend_ff.last_row || pend_ff.right || pend_ff.right_last;

   assign out_move = !vo_ff || rsp.ready;
   assign free3    = !v3_ff || out_move;
   assign free2    = !v2_ff || free3;
   assign free1    = !v1_ff || free2;
   assign issue    = any && free1;

   // pick the earliest pending result and the window taps it uses
   always_comb begin
      rem       = pend_ff;
      sel_frame = 1'b0;
      lc = pend_ff.left_rep ? 2'd1 : 2'd0;
      cc = 2'd1;
      rc = 2'd2;
      ur = 2'd0;
      mr = 2'd1;
      dr = 2'd2;
      if (pend_ff.main) begin
         rem.main = 1'b0;
      end else if (pend_ff.last_row) begin
         rem.last_row = 1'b0;
         ur = 2'd1;
         mr = 2'd2;
      end else if (pend_ff.right) begin
         rem.right = 1'b0;
         lc = 2'd1;
         cc = 2'd2;
      end else begin
         rem.right_last = 1'b0;
         sel_frame = 1'b1;
         lc = 2'd1;
         cc = 2'd2;
         ur = 2'd1;
         mr = 2'd2;
      end
   end

   assign rem_empty = !(rem.main || rem.last_row || rem.right || rem.right_last);
   assign q_ready   = !any || (free1 && rem_empty);
   assign pop       = q_valid && q_ready;

   always_comb begin
      pend_in = pend_ff;
      if (pop) begin
         pend_in = q_job.emit;
      end else if (issue) begin
         pend_in = rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         vo_ff   <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[c][r] <= '0;
            end
         end
      end else begin
         pend_ff <= pend_in;
         if (free1) v1_ff <= issue;
         if (free2) v2_ff <= v1_ff;
         if (free3) v3_ff <= v2_ff;
         if (out_move) vo_ff <= v3_ff;
         if (pop) begin
            win_ff[0]    <= win_ff[1];
            win_ff[1]    <= win_ff[2];
            win_ff[2][0] <= q_job.col.top;
            win_ff[2][1] <= q_job.col.mid;
            win_ff[2][2] <= q_job.col.cur;
         end
      end
   end

   // stage 1: gather centre and neighbours
   always_ff @(posedge clock) begin
      if (free1 && issue) begin
         s1_ctr_ff   <= win_ff[cc][mr];
         s1_nb_ff[0] <= win_ff[lc][ur];
         s1_nb_ff[1] <= win_ff[cc][ur];
         s1_nb_ff[2] <= win_ff[rc][ur];
         s1_nb_ff[3] <= win_ff[lc][mr];
         s1_nb_ff[4] <= win_ff[rc][mr];
         s1_nb_ff[5] <= win_ff[lc][dr];
         s1_nb_ff[6] <= win_ff[cc][dr];
         s1_nb_ff[7] <= win_ff[rc][dr];
         s1_fe_ff    <= sel_frame;
         s1_lr_ff    <= rem_empty;
      end
   end

   // stage 2: high-pass sum
   always_ff @(posedge clock) begin
      if (free2 && v1_ff) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            s2_hp_ff[ch] <= $signed({2'b00, s1_ctr_ff[ch], 3'b000})
               - $signed(HP_W'({5'b0, s1_nb_ff[0][ch]} + {5'b0, s1_nb_ff[1][ch]}
                             + {5'b0, s1_nb_ff[2][ch]} + {5'b0, s1_nb_ff[3][ch]}
                             + {5'b0, s1_nb_ff[4][ch]} + {5'b0, s1_nb_ff[5][ch]}
                             + {5'b0, s1_nb_ff[6][ch]} + {5'b0, s1_nb_ff[7][ch]}));
         end
         s2_ctr_ff <= s1_ctr_ff;
         s2_fe_ff  <= s1_fe_ff;
         s2_lr_ff  <= s1_lr_ff;
      end
   end

   // stage 3: scale by gain
   always_ff @(posedge clock) begin
      if (free3 && v2_ff) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            s3_prod_ff[ch] <= PROD_W'($signed({1'b0, cfg.amount}) * s2_hp_ff[ch]);
         end
         s3_ctr_ff <= s2_ctr_ff;
         s3_fe_ff  <= s2_fe_ff;
         s3_lr_ff  <= s2_lr_ff;
      end
   end

   // output: add centre, round half up, clamp
   always_comb begin
      logic signed [PROD_W+1:0] num;
      logic [PROD_W-10:0]       shifted;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         num = $signed({7'b0, s3_ctr_ff[ch], 11'b0}) + (PROD_W+2)'(s3_prod_ff[ch])
               + $signed((PROD_W+2)'(1024));
         shifted = num[PROD_W+1:11];
         if (num < 0) begin
            o_val_in[ch] = '0;
         end else if (shifted > (PROD_W-9)'(cfg.mask)) begin
            o_val_in[ch] = cfg.mask;
         end else begin
            o_val_in[ch] = shifted[SAMPLE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_move && v3_ff) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            o_val_ff[ch] <= o_val_in[ch];
         end
         o_fe_ff <= s3_fe_ff;
         o_lr_ff <= s3_lr_ff;
      end
   end

   assign rsp.valid       = vo_ff;
   assign rsp.out_r       = o_val_ff[0];
   assign rsp.out_g       = o_val_ff[1];
   assign rsp.out_b       = o_val_ff[2];
   assign rsp.frame_end   = o_fe_ff;
   assign rsp.last_of_run = o_lr_ff;
endmodule

// ----- rtl/core/high_pass_sharpen_3x3.sv -----
// 3x3 high-pass sharpen on an RGB raster stream.
// Throughput: one pixel per cycle while the output is not stalled; a pixel
// with k results (k = 0..4) issues them in turn via the single issue slot.
// Reset (synchronous) clears counters, window, queue and valids and loads
// width 640, height 480, gain 1.0 and 8-bit samples; line RAM is not cleared.
module high_pass_sharpen_3x3 (
   input  logic                   clock,
   input  logic                   reset,
   hps_req_if.sink                req_if,
   hps_rsp_if.source              rsp_if,
   input  logic                   csr_we,
   input  hps_pkg::csr_index_type csr_index,
   input  logic [12:0]            csr_wdata
);
   import hps_pkg::*;

   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [AMT_W-1:0]  amount_ff;
   logic [BITS_W-1:0] bits_ff;
   logic              restart;
   cfg_type           cfg;
   logic [BITS_W-1:0] bits_sat;
   logic              q_in_valid, q_in_ready, q_out_valid, q_out_ready;
   job_type           q_in_job, q_out_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         amount_ff <= RESET_AMOUNT;
         bits_ff   <= RESET_BITS;
      end else if (csr_we) begin
         case (csr_index)
            REG_FRAME_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            REG_FRAME_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            REG_AMOUNT:       amount_ff <= csr_wdata[AMT_W-1:0];
            REG_SAMPLE_BITS:  bits_ff   <= csr_wdata[BITS_W-1:0];
            default: ;
         endcase
      end
   end

   assign restart = csr_we &&
                    (csr_index == REG_FRAME_WIDTH || csr_index == REG_FRAME_HEIGHT);

   always_comb begin
      if (CMP_W'(width_ff) < CMP_W'(3))               cfg.width = CMP_W'(3);
      else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH))  cfg.width = CMP_W'(MAX_WIDTH);
      else                                            cfg.width = CMP_W'(width_ff);
      if (CMP_W'(height_ff) < CMP_W'(3))              cfg.height = CMP_W'(3);
      else if (CMP_W'(height_ff) > CMP_W'(MAX_HEIGHT)) cfg.height = CMP_W'(MAX_HEIGHT);
      else                                            cfg.height = CMP_W'(height_ff);
      cfg.amount = (amount_ff > AMT_W'(AMT_MAX)) ? AMT_W'(AMT_MAX) : amount_ff;
      if (bits_ff == '0)                      bits_sat = BITS_W'(1);
      else if (bits_ff > BITS_W'(SAMPLE_W))   bits_sat = BITS_W'(SAMPLE_W);
      else                                    bits_sat = bits_ff;
      cfg.mask = SAMPLE_W'(((SAMPLE_W+1)'(1) << bits_sat) - (SAMPLE_W+1)'(1));
   end

   hps_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .cfg     (cfg),
      .restart (restart),
      .q_valid (q_in_valid),
      .q_ready (q_in_ready),
      .q_job   (q_in_job)
   );

   hps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_job    (q_in_job),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_job   (q_out_job)
   );

   hps_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_out_valid),
      .q_ready (q_out_ready),
      .q_job   (q_out_job),
      .cfg     (cfg),
      .rsp     (rsp_if)
   );
endmodule

// ----- rtl/core/hps_checker.sv -----
module hps_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] out_r,
   input logic [15:0] out_g,
   input logic [15:0] out_b,
   input logic        frame_end,
   input logic        last_of_run
);
   // a stalled transfer keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_r) && $stable(out_g) &&
                                  $stable(out_b) && $stable(frame_end) &&
                                  $stable(last_of_run))
      else $error("rsp payload changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // the frame's closing pixel always ends its run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_end |-> last_of_run)
      else $error("frame_end without last_of_run");
endmodule

bind high_pass_sharpen_3x3 hps_checker u_hps_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .out_r       (rsp_if.out_r),
   .out_g       (rsp_if.out_g),
   .out_b       (rsp_if.out_b),
   .frame_end   (rsp_if.frame_end),
   .last_of_run (rsp_if.last_of_run)
);

// ----- tb/tb_high_pass_sharpen_3x3.sv -----
module tb_high_pass_sharpen_3x3;
   timeunit 1ns;
   timeprecision 1ps;

   import hps_pkg::*;

   typedef struct {
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
      logic        frame_end;
      logic        last_of_run;
   } sharp_px_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   csr_index_type csr_index = REG_FRAME_WIDTH;
   logic [12:0] csr_wdata = '0;

   hps_req_if req_if ();
   hps_rsp_if rsp_if ();

   high_pass_sharpen_3x3 dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [12:0] width_reg, height_reg;
   logic [9:0]  amount_reg;
   logic [4:0]  bits_reg;
   pixel_type   row_above_buf [MAX_WIDTH];
   pixel_type   row_middle_buf [MAX_WIDTH];
   pixel_type   nbhd [3][3];   // [column][row]
   int          col_pos, row_pos;

   sharp_px_type sharp_q[$];
   bit  failed = 1'b0;
   bit  calm = 1'b0;        // no idling on either side
   int  rsp_hold_cycles = 0;

   function automatic int clip(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic sharp_px_type sharpen(int l, int c, int r, int u, int m, int d,
                                            longint amt, longint maxv);
      sharp_px_type res;
      longint v[3];
      longint ctr, nb, hp, num;
      for (int ch = 0; ch < 3; ch++) begin
         ctr = nbhd[c][m][ch];
         nb = longint'(nbhd[l][u][ch]) + nbhd[c][u][ch] + nbhd[r][u][ch]
            + nbhd[l][m][ch] + nbhd[r][m][ch]
            + nbhd[l][d][ch] + nbhd[c][d][ch] + nbhd[r][d][ch];
         hp = 8 * ctr - nb;
         num = 2048 * ctr + amt * hp + 1024;
         v[ch] = num < 0 ? 0 : (num >>> 11);
         if (v[ch] > maxv) v[ch] = maxv;
      end
      res.r = v[0][15:0];
      res.g = v[1][15:0];
      res.b = v[2][15:0];
      res.frame_end = 1'b0;
      res.last_of_run = 1'b0;
      return res;
   endfunction

   function automatic void predict_sharpen(pixel_type px);
      int w, h, amt, nbits, x, y, n, l;
      logic [15:0] mask;
      pixel_type cur, top, mid;
      sharp_px_type res [4];
      w = clip(width_reg, 3, MAX_WIDTH);
      h = clip(height_reg, 3, MAX_HEIGHT);
      amt = amount_reg > AMT_MAX ? AMT_MAX : amount_reg;
      nbits = clip(bits_reg, 1, 16);
      mask = 16'((32'd1 << nbits) - 1);
      x = col_pos;
      y = row_pos;
      n = 0;
      if (x >= w || y >= h) begin
         x = 0;
         y = 0;
      end
      for (int ch = 0; ch < 3; ch++) cur[ch] = px[ch] & mask;
      if (y >= 1) begin
         mid = row_middle_buf[x];
         top = (y >= 2) ? row_above_buf[x] : mid;
         row_above_buf[x] = mid;
      end else begin
         mid = cur;
         top = cur;
      end
      row_middle_buf[x] = cur;
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 3; j++) nbhd[i][j] = nbhd[i+1][j];
      nbhd[2][0] = top;
      nbhd[2][1] = mid;
      nbhd[2][2] = cur;
      if (y >= 1 && x >= 1) begin
         l = (x == 1) ? 1 : 0;
         res[n++] = sharpen(l, 1, 2, 0, 1, 2, amt, mask);
         if (y == h - 1) res[n++] = sharpen(l, 1, 2, 1, 2, 2, amt, mask);
         if (x == w - 1) begin
            res[n++] = sharpen(1, 2, 2, 0, 1, 2, amt, mask);
            if (y == h - 1) begin
               res[n] = sharpen(1, 2, 2, 1, 2, 2, amt, mask);
               res[n].frame_end = 1'b1;
               n++;
            end
         end
      end
      if (n > 0) res[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) sharp_q.push_back(res[i]);
      x++;
      if (x >= w) begin
         x = 0;
         y++;
         if (y >= h) y = 0;
      end
      col_pos = x;
      row_pos = y;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (calm || p < 55) return 0;
      if (p < 90) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   // response side: check each transfer, then choose next ready
   initial begin
      sharp_px_type want;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (sharp_q.size() == 0) begin
               $error("unexpected result r=%h g=%h b=%h", rsp_if.out_r, rsp_if.out_g,
                      rsp_if.out_b);
               failed = 1'b1;
            end else begin
               want = sharp_q.pop_front();
               if (rsp_if.out_r !== want.r) begin
                  $error("out_r: expected %h, got %h", want.r, rsp_if.out_r);
                  failed = 1'b1;
               end
               if (rsp_if.out_g !== want.g) begin
                  $error("out_g: expected %h, got %h", want.g, rsp_if.out_g);
                  failed = 1'b1;
               end
               if (rsp_if.out_b !== want.b) begin
                  $error("out_b: expected %h, got %h", want.b, rsp_if.out_b);
                  failed = 1'b1;
               end
               if (rsp_if.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %b, got %b", want.frame_end,
                         rsp_if.frame_end);
                  failed = 1'b1;
               end
               if (rsp_if.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %b, got %b", want.last_of_run,
                         rsp_if.last_of_run);
                  failed = 1'b1;
               end
            end
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= (pick_gap() == 0);
         end
      end
   end

   task automatic send_pixel(pixel_type px);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.sample_r <= px[0];
      req_if.sample_g <= px[1];
      req_if.sample_b <= px[2];
      do @(posedge clock); while (!req_if.ready);
      predict_sharpen(px);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sharp_q.size() != 0) @(posedge clock);
      // pixels with no result may still be in flight
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [12:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_FRAME_WIDTH: begin
            width_reg = value;
            col_pos = 0;
            row_pos = 0;
         end
         REG_FRAME_HEIGHT: begin
            height_reg = value;
            col_pos = 0;
            row_pos = 0;
         end
         REG_AMOUNT: amount_reg = value[9:0];
         REG_SAMPLE_BITS: bits_reg = value[4:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic pixel_type rand_pixel();
      pixel_type px;
      for (int ch = 0; ch < 3; ch++) px[ch] = 16'($urandom);
      return px;
   endfunction

   task automatic send_frame(int w, int h, bit may_abort);
      int stop_at;
      stop_at = (may_abort && $urandom_range(9) == 0) ? $urandom_range(w * h - 1, 1) : w * h;
      for (int i = 0; i < stop_at; i++) send_pixel(rand_pixel());
   endtask

   // default gain and sample width on the smallest frame
   task automatic test_reset_defaults();
      write_csr(REG_FRAME_WIDTH, 13'd3);
      write_csr(REG_FRAME_HEIGHT, 13'd3);
      for (int i = 0; i < 9; i++) send_pixel(rand_pixel());
      wait_drained();
   endtask

   // full-scale checkerboard at maximum gain and 16-bit samples
   task automatic test_extreme_samples();
      write_csr(REG_AMOUNT, 13'd768);
      write_csr(REG_SAMPLE_BITS, 13'd16);
      for (int i = 0; i < 9; i++)
         send_pixel((i % 2) ? {48{1'b1}} : {16'hFFFF, 16'h0000, 16'hFFFF});
      wait_drained();
   endtask

   // out-of-range register values saturate; wide samples are masked
   task automatic test_register_saturation();
      write_csr(REG_FRAME_WIDTH, 13'd1);
      write_csr(REG_FRAME_HEIGHT, 13'd2);
      write_csr(REG_AMOUNT, 13'h3FF);
      write_csr(REG_SAMPLE_BITS, 13'd0);
      for (int i = 0; i < 9; i++) send_pixel(rand_pixel());
      wait_drained();
      write_csr(REG_SAMPLE_BITS, 13'h1F);
      write_csr(REG_AMOUNT, 13'd0);
      write_csr(REG_FRAME_WIDTH, 13'h1FFF);
      write_csr(REG_FRAME_HEIGHT, 13'h1FFF);
   endtask

   task automatic test_random_frames(int budget);
      int sent, w, h;
      sent = 0;
      while (sent < budget) begin
         w = ($urandom_range(4) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 3);
         h = $urandom_range(5, 3);
         write_csr(REG_FRAME_WIDTH, 13'(w));
         write_csr(REG_FRAME_HEIGHT, 13'(h));
         case ($urandom_range(3))
            0: write_csr(REG_AMOUNT, 13'd0);
            1: write_csr(REG_AMOUNT, 13'd768);
            default: write_csr(REG_AMOUNT, 13'($urandom_range(1023)));
         endcase
         write_csr(REG_SAMPLE_BITS, 13'($urandom_range(31)));
         calm = ($urandom_range(4) == 0);
         send_frame(w, h, 1'b1);
         sent += w * h;
         // sometimes run a second frame back to back
         if ($urandom_range(2) == 0) begin
            send_frame(w, h, 1'b0);
            sent += w * h;
         end
         calm = 1'b0;
         wait_drained();
      end
   endtask

   // hold the result side long enough that the input stalls
   task automatic test_output_stall();
      write_csr(REG_FRAME_WIDTH, 13'd6);
      write_csr(REG_FRAME_HEIGHT, 13'd4);
      write_csr(REG_AMOUNT, 13'd384);
      write_csr(REG_SAMPLE_BITS, 13'd12);
      rsp_hold_cycles = 200;
      calm = 1'b1;
      send_frame(6, 4, 1'b0);
      calm = 1'b0;
      wait_drained();
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.sample_r = '0;
      req_if.sample_g = '0;
      req_if.sample_b = '0;
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      amount_reg = RESET_AMOUNT;
      bits_reg = RESET_BITS;
      col_pos = 0;
      row_pos = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) nbhd[i][j] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_extreme_samples();
      test_register_saturation();
      test_output_stall();
      test_random_frames(100);
      wait_drained();
      if (!failed) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/hps_pkg.sv
rtl/core/hps_req_if.sv
rtl/core/hps_rsp_if.sv
rtl/core/hps_ram.sv
rtl/core/hps_front.sv
rtl/core/hps_queue.sv
rtl/core/hps_back.sv
rtl/core/high_pass_sharpen_3x3.sv
rtl/core/hps_checker.sv
tb/tb_high_pass_sharpen_3x3.sv
